@@ hw/rtl/sirp_pkg.sv @@
`default_nettype none

package sirp_pkg;

  // Width of the bound and answer fields
  localparam int VALUE_W = 63;

  // Width of a one-bit count and of the ones_wanted field
  localparam int COUNT_W = 6;

  // Default number of value bits taken from each bound
  localparam int DEF_VALUE_BITS = 63;

endpackage

`default_nettype wire

@@ hw/rtl/smallest_in_range_with_popcount_unit.sv @@
// An accepted query word passes the input, count stage and result registers to the result port.
// Throughput: one query word per cycle, sustained; the input register, the count stage and
// the result register each hold one word, so a stalled result blocks queries only once all are full.
// The longest path is the prefix count network over VALUE_BITS bits followed by the
// lowest-candidate pick in the count stage.
// Reset (rst, synchronous) clears every valid flag; payload registers keep their contents.
`default_nettype none

module smallest_in_range_with_popcount_unit
  import sirp_pkg::*;
#(
  parameter int VALUE_BITS = DEF_VALUE_BITS
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               query_valid,
  output logic                    query_stall,
  input  wire logic [VALUE_W-1:0] lower_bound,
  input  wire logic [VALUE_W-1:0] upper_bound,
  input  wire logic [COUNT_W-1:0] ones_wanted,
  output logic                    result_valid,
  input  wire logic               result_stall,
  output logic [VALUE_W-1:0]      answer_value,
  output logic                    found
);

  localparam int LEVELS = $clog2(VALUE_BITS);

  // Input register
  logic                  q_valid;
  logic [VALUE_BITS-1:0] q_lo;
  logic [VALUE_BITS-1:0] q_hi;
  logic [COUNT_W-1:0]    q_want;

  // Count stage register
  logic                  s_valid;
  logic [VALUE_BITS-1:0] s_lo;
  logic [VALUE_BITS-1:0] s_hi;
  logic [COUNT_W-1:0]    s_want;
  logic                  s_case_a;
  logic [VALUE_BITS-1:0] s_fill_a;
  logic [VALUE_BITS-1:0] s_onehot;
  logic [COUNT_W-1:0]    s_sp;
  logic                  s_ok;

  // Stage enables
  logic out_en;
  logic s_en;
  logic q_en;

  // Advance a stage when the one after it is empty or moving
  assign out_en      = !result_valid || !result_stall;
  assign s_en        = !s_valid || out_en;
  assign q_en        = !q_valid || s_en;
  assign query_stall = !q_en;

  // Capture the query word, keeping only the value bits in use
  always_ff @(posedge clk) begin
    if (rst) begin
      q_valid <= 1'b0;
    end else if (q_en) begin
      q_valid <= query_valid;
    end
    if (q_en) begin
      q_lo   <= lower_bound[VALUE_BITS-1:0];
      q_hi   <= upper_bound[VALUE_BITS-1:0];
      q_want <= ones_wanted;
    end
  end

  // Count network: ones at or above each bit, zeros at or below each bit
  logic [COUNT_W-1:0]    suf [0:LEVELS][0:VALUE_BITS-1];
  logic [COUNT_W-1:0]    pre [0:LEVELS][0:VALUE_BITS-1];
  logic [COUNT_W-1:0]    pc_lo;
  logic                  case_a;
  logic [VALUE_BITS-1:0] cand;
  logic [VALUE_BITS-1:0] onehot;
  logic [VALUE_BITS-1:0] fill_a;
  logic [COUNT_W-1:0]    sp;
  logic                  ok0;

  always_comb begin
    for (int i = 0; i < VALUE_BITS; i++) begin
      suf[0][i] = COUNT_W'(q_lo[i]);
      pre[0][i] = COUNT_W'(!q_lo[i]);
    end
    for (int k = 0; k < LEVELS; k++) begin
      for (int i = 0; i < VALUE_BITS; i++) begin
        if (i + (1 << k) < VALUE_BITS) begin
          suf[k+1][i] = suf[k][i] + suf[k][i + (1 << k)];
        end else begin
          suf[k+1][i] = suf[k][i];
        end
        if (i >= (1 << k)) begin
          pre[k+1][i] = pre[k][i] + pre[k][i - (1 << k)];
        end else begin
          pre[k+1][i] = pre[k][i];
        end
      end
    end
  end

  // Pick the rounding point or the zero bits to fill
  always_comb begin
    pc_lo  = suf[LEVELS][0];
    case_a = pc_lo <= q_want;
    for (int i = 0; i < VALUE_BITS; i++) begin
      // a zero bit with fewer than the wanted ones above it may take the carry
      cand[i]   = !q_lo[i] && (suf[LEVELS][i] < q_want);
      // fill the lowest zeros until the count is reached
      fill_a[i] = !q_lo[i] &&
                  ({1'b0, pre[LEVELS][i]} + {1'b0, pc_lo} <= {1'b0, q_want});
    end
    onehot = cand & (~cand + VALUE_BITS'(1));
    sp     = '0;
    for (int i = 0; i < VALUE_BITS; i++) begin
      sp = sp | (onehot[i] ? suf[LEVELS][i] : COUNT_W'(0));
    end
    ok0 = (q_lo <= q_hi) && (q_want <= COUNT_W'(VALUE_BITS)) && (case_a || (|cand));
  end

  // Hold the partial result in the count stage register
  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid <= 1'b0;
    end else if (s_en) begin
      s_valid <= q_valid;
    end
    if (s_en) begin
      s_lo     <= q_lo;
      s_hi     <= q_hi;
      s_want   <= q_want;
      s_case_a <= case_a;
      s_fill_a <= fill_a;
      s_onehot <= onehot;
      s_sp     <= sp;
      s_ok     <= ok0;
    end
  end

  // Build the candidate value and check it against the upper bound
  logic [VALUE_BITS-1:0] keep;
  logic [COUNT_W-1:0]    db;
  logic [VALUE_BITS-1:0] low_fill;
  logic [VALUE_BITS-1:0] xa;
  logic [VALUE_BITS-1:0] xb;
  logic [VALUE_BITS-1:0] x;
  logic                  ok;

  always_comb begin
    // drop the bits at and below the carry point, set the carry bit, refill the bottom
    keep     = ~((s_onehot << 1) - VALUE_BITS'(1));
    db       = s_want - s_sp - COUNT_W'(1);
    low_fill = (VALUE_BITS'(1) << db) - VALUE_BITS'(1);
    xb       = (s_lo & keep) | s_onehot | low_fill;
    xa       = s_lo | s_fill_a;
    x        = s_case_a ? xa : xb;
    ok       = s_ok && (x <= s_hi);
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (out_en) begin
      result_valid <= s_valid;
    end
    if (out_en) begin
      answer_value <= ok ? VALUE_W'(x) : '0;
      found        <= ok;
    end
  end

`ifndef SYNTH
  a_miss_is_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && !found |-> answer_value == '0)
    else $error("result word without a match carries a nonzero value");

  a_answer_in_width: assert property (@(posedge clk) disable iff (rst)
    result_valid && found |-> (answer_value >> VALUE_BITS) == '0)
    else $error("answer has bits above the value width");

  a_single_carry: assert property (@(posedge clk) disable iff (rst)
    s_valid && s_ok && !s_case_a |-> $onehot(s_onehot))
    else $error("carry point is not a single bit");

  a_full_blocks: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall && s_valid && q_valid |-> query_stall)
    else $error("query accepted while every stage is held");

  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !result_valid)
    else $error("result valid straight after reset");
`endif

endmodule

`default_nettype wire

@@ tb/tb_smallest_in_range_with_popcount_unit.sv @@
`timescale 1ns / 100ps

module tb_smallest_in_range_with_popcount_unit;
  import sirp_pkg::*;

  localparam int VALUE_BITS = DEF_VALUE_BITS;
  localparam logic [VALUE_W-1:0] ALL_ONES = '1;

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic               found;
  } answer_t;

  logic               clk = 1'b0;
  logic               rst;
  logic               query_valid;
  logic               query_stall;
  logic [VALUE_W-1:0] lower_bound;
  logic [VALUE_W-1:0] upper_bound;
  logic [COUNT_W-1:0] ones_wanted;
  logic               result_valid;
  logic               result_stall;
  logic [VALUE_W-1:0] answer_value;
  logic               found;

  // answers still owed by the block, oldest first
  answer_t answer_q[$];
  int      error_count = 0;
  bit      steady = 1'b0;

  smallest_in_range_with_popcount_unit #(
    .VALUE_BITS(VALUE_BITS)
  ) dut (
    .clk         (clk),
    .rst         (rst),
    .query_valid (query_valid),
    .query_stall (query_stall),
    .lower_bound (lower_bound),
    .upper_bound (upper_bound),
    .ones_wanted (ones_wanted),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .answer_value(answer_value),
    .found       (found)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Walk the candidate up: drop ones by adding the lowest set bit, then fill low zeros
  function automatic answer_t smallest_with_ones(input logic [VALUE_W-1:0] lo_in,
                                                 input logic [VALUE_W-1:0] hi_in,
                                                 input logic [COUNT_W-1:0] want_in);
    logic [63:0] mask;
    logic [63:0] lo;
    logic [63:0] hi;
    logic [63:0] x;
    logic [63:0] low_bit;
    int          want;
    bit          ok;
    answer_t     res;
    mask = (64'd1 << VALUE_BITS) - 64'd1;
    lo   = 64'(lo_in) & mask;
    hi   = 64'(hi_in) & mask;
    want = int'(want_in);
    x    = lo;
    ok   = !(lo > hi || want > VALUE_BITS);
    for (int i = 0; ok && i < 64 && $countones(x) > want; i++) begin
      low_bit = x & (~x + 64'd1);
      x = x + low_bit;
      if (x > mask || x == 64'd0) ok = 1'b0;
    end
    for (int i = 0; ok && i < 64 && $countones(x) < want; i++) begin
      x = x | (x + 64'd1);
      if (x > mask) ok = 1'b0;
    end
    if (ok && ($countones(x) != want || x > hi)) ok = 1'b0;
    res.value = ok ? x[VALUE_W-1:0] : '0;
    res.found = ok;
    return res;
  endfunction

  function automatic logic [VALUE_W-1:0] rand_value();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return r[VALUE_W-1:0];
  endfunction

  // Present one query word, hold it until taken, then log its answer
  task automatic send_query(input logic [VALUE_W-1:0] lo, input logic [VALUE_W-1:0] hi,
                            input logic [COUNT_W-1:0] want);
    @(negedge clk);
    while (!steady && $urandom_range(0, 99) < 33) begin
      query_valid <= 1'b0;
      @(negedge clk);
    end
    query_valid <= 1'b1;
    lower_bound <= lo;
    upper_bound <= hi;
    ones_wanted <= want;
    do @(posedge clk); while (query_stall);
    answer_q.insert(answer_q.size(), smallest_with_ones(lo, hi, want));
  endtask

  task automatic stop_queries();
    @(negedge clk);
    query_valid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (answer_q.size() != 0) @(posedge clk);
  endtask

  // Random result stall, off during the steady stretch
  always @(negedge clk) begin
    result_stall <= !steady && ($urandom_range(0, 99) < 33);
  end

  // Compare each result word with the oldest logged answer
  always @(posedge clk) begin
    answer_t exp_ans;
    if (!rst && result_valid && !result_stall) begin
      if (answer_q.size() == 0) begin
        $error("unexpected result word: answer_value=%h found=%b", answer_value, found);
        error_count++;
      end else begin
        exp_ans = answer_q.pop_front();
        if (answer_value !== exp_ans.value) begin
          $error("answer_value: expected %h, got %h", exp_ans.value, answer_value);
          error_count++;
        end
        if (found !== exp_ans.found) begin
          $error("found: expected %b, got %b", exp_ans.found, found);
          error_count++;
        end
      end
    end
  end

  task automatic test_extremes();
    send_query('0, '0, '0);
    send_query('0, '0, 6'd1);
    send_query('0, ALL_ONES, 6'd63);
    send_query('0, ALL_ONES, 6'd62);
    send_query(ALL_ONES, ALL_ONES, 6'd63);
    send_query(ALL_ONES, ALL_ONES, '0);
    send_query(ALL_ONES, ALL_ONES, 6'd1);
    send_query(VALUE_W'({VALUE_W/2+1{2'b01}}), ALL_ONES, 6'd32);
    send_query(VALUE_W'({VALUE_W/2{2'b10}}), {1'b1, {VALUE_W/2{2'b01}}}, 6'd31);
  endtask

  task automatic test_paths();
    // lower bound already has the wanted count
    send_query(63'd10, 63'd100, 6'd2);
    // too few ones: fill the lowest zeros
    send_query(63'd8, 63'd100, 6'd3);
    send_query(63'd8, 63'd10, 6'd3);
    // too many ones: step up to drop ones
    send_query(63'd7, 63'd100, 6'd1);
    send_query(63'd7, 63'd7, 6'd1);
    send_query(63'd13, 63'd1000, 6'd2);
  endtask

  task automatic test_special_cases();
    // crossed bounds
    send_query(63'd5, 63'd4, 6'd2);
    send_query(ALL_ONES, '0, '0);
    // upper bound below the smallest value with that count
    send_query('0, 63'd6, 6'd3);
    // search runs off the top of the value range
    send_query((63'd1 << 62) | 63'd1, ALL_ONES, 6'd1);
    send_query(ALL_ONES - 63'd1, ALL_ONES, 6'd61);
    // zero ones wanted
    send_query('0, 63'd50, '0);
    send_query(63'd1, ALL_ONES, '0);
  endtask

  task automatic test_random(input int count);
    logic [VALUE_W-1:0] lo;
    logic [VALUE_W-1:0] hi;
    int                 want;
    for (int n = 0; n < count; n++) begin
      steady = (n >= count / 3) && (n < count / 3 + 150);
      lo = rand_value();
      hi = rand_value();
      want = $urandom_range(0, 63);
      case ($urandom_range(0, 9))
        0, 1: begin
          // small values, small counts
          lo = lo & 63'hff;
          hi = lo + 63'($urandom_range(0, 200));
          want = $urandom_range(0, 9);
        end
        2, 3: begin
          // tight range with a count near that of the lower bound
          hi = lo + 63'($urandom_range(0, 4096));
          want = $countones(lo) + $urandom_range(0, 6) - 3;
          if (want < 0) want = 0;
          if (want > 63) want = 63;
        end
        4, 5: begin
          hi = ALL_ONES;
          want = $countones(lo) + $urandom_range(0, 10) - 5;
          if (want < 0) want = 0;
          if (want > 63) want = 63;
        end
        6: begin
          // lower bound with a sparse pattern
          lo = lo & rand_value() & rand_value();
          if (hi < lo) hi = ALL_ONES;
        end
        default: begin
          if (hi < lo && $urandom_range(0, 3) != 0) hi = ALL_ONES;
        end
      endcase
      send_query(lo, hi, COUNT_W'(want));
    end
    steady = 1'b0;
  endtask

  // Hold the sender until every answer is back, then carry on
  task automatic test_drain_pause();
    for (int n = 0; n < 12; n++) begin
      send_query(rand_value(), ALL_ONES, COUNT_W'($urandom_range(0, 63)));
    end
    stop_queries();
    wait_drained();
    for (int n = 0; n < 12; n++) begin
      send_query(rand_value() >> 40, ALL_ONES, COUNT_W'($urandom_range(0, 24)));
    end
  endtask

  initial begin
    rst          = 1'b1;
    query_valid  = 1'b0;
    lower_bound  = '0;
    upper_bound  = '0;
    ones_wanted  = '0;
    repeat (10) @(negedge clk);
    rst <= 1'b0;
    test_extremes();
    test_paths();
    test_special_cases();
    test_drain_pause();
    test_random(700);
    stop_queries();
    wait_drained();
    repeat (10) @(posedge clk);
    if (error_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
